[rtl/core/oidst_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered id set table package
// Shared item types, operation codes and the control state encoding.
// ----------------------------------------------------------------------------
package oidst_pkg;

   typedef logic [1:0] op_type;

   localparam op_type OP_LOOKUP = 2'd0;
   localparam op_type OP_ADD    = 2'd1;
   localparam op_type OP_DELETE = 2'd2;

   typedef struct packed {
      op_type      op;
      logic [31:0] conn_id;
      logic [31:0] entry_payload;
   } req_type;

   typedef struct packed {
      logic       status;
      logic       found;
      logic [3:0] index;
      logic [4:0] count;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_RESOLVE
   } state_type;

endpackage

[rtl/core/oidst_cell.sv]
// ----------------------------------------------------------------------------
// Ordered id set table cell
// Holds one entry, compares its id against the request and takes either a new
// entry or the contents of its upper neighbor.
// ----------------------------------------------------------------------------
module oidst_cell
   import oidst_pkg::*;
#(
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic [31:0]              cmp_id,
   input  logic [31:0]              new_id,
   input  logic [PAYLOAD_WIDTH-1:0] new_data,
   input  logic [31:0]              nbr_id,
   input  logic [PAYLOAD_WIDTH-1:0] nbr_data,
   output logic [31:0]              id_ff,
   output logic [PAYLOAD_WIDTH-1:0] data_ff,
   output logic                     match_ff
);

   logic [31:0]              id_in;
   logic [PAYLOAD_WIDTH-1:0] data_in;
   logic                     match_in;

   always_comb begin
      id_in    = id_ff;
      data_in  = data_ff;
      match_in = ctrl.valid && (id_ff == cmp_id);
      if (ctrl.load) begin
         id_in   = new_id;
         data_in = new_data;
      end else if (ctrl.shift) begin
         id_in   = nbr_id;
         data_in = nbr_data;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      data_ff  <= data_in;
      match_ff <= match_in;
   end

endmodule

[rtl/core/ordered_id_set_table_core.sv]
// ----------------------------------------------------------------------------
// Ordered id set table core
// An accepted item is compared by the registered cell row in the match step,
// then resolved and applied in the resolve and update step, which waits
// while a held result is not taken; only then is a new item accepted.
// Reset clears the entry count, the control state and the result valid flag;
// entry contents stay undefined until written.
// ----------------------------------------------------------------------------
module ordered_id_set_table_core
   import oidst_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [31:0]              cell_id   [DEPTH+1];
   logic [PAYLOAD_WIDTH-1:0] cell_data [DEPTH+1];
   logic [DEPTH-1:0]         match;
   cell_ctrl_type            ctrl [DEPTH];

   logic [PAYLOAD_WIDTH+31:0] payload_wide;
   logic [PAYLOAD_WIDTH-1:0]  new_data;
   logic [IDX_W-1:0]          hit_idx;
   logic [IDX_W+3:0]          idx_wide;
   logic [CNT_W+4:0]          cnt_wide;
   logic                      found;
   logic                      full;
   logic                      add_ok;
   logic                      del_ok;
   logic                      fire;
   logic                      update;

   assign payload_wide = {{PAYLOAD_WIDTH{1'b0}}, req_ff.entry_payload};
   assign new_data     = payload_wide[PAYLOAD_WIDTH-1:0];

   assign cell_id[DEPTH]   = '0;
   assign cell_data[DEPTH] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         always_comb begin
            ctrl[gi].valid = CNT_W'(gi) < count_ff;
            ctrl[gi].load  = update && add_ok && (CNT_W'(gi) == count_ff);
            ctrl[gi].shift = update && del_ok && (IDX_W'(gi) >= hit_idx);
         end

         oidst_cell #(
            .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl[gi]),
            .cmp_id   (req_ff.conn_id),
            .new_id   (req_ff.conn_id),
            .new_data (new_data),
            .nbr_id   (cell_id[gi+1]),
            .nbr_data (cell_data[gi+1]),
            .id_ff    (cell_id[gi]),
            .data_ff  (cell_data[gi]),
            .match_ff (match[gi])
         );
      end
   endgenerate

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_idx = hit_idx | (match[i] ? IDX_W'(i) : '0);
      end
   end

   assign found    = |match;
   assign full     = count_ff == CNT_W'(DEPTH);
   assign add_ok   = (req_ff.op == OP_ADD) && !found && !full;
   assign del_ok   = (req_ff.op == OP_DELETE) && found;
   assign fire     = !rsp_valid_ff || rsp_ready;
   assign update   = (state_ff == ST_RESOLVE) && fire;
   assign idx_wide = {4'b0, hit_idx};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cnt_wide     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (fire) begin
               count_in      = count_ff + CNT_W'(add_ok) - CNT_W'(del_ok);
               cnt_wide      = {5'b0, count_in};
               rsp_in.status = !(((req_ff.op == OP_LOOKUP) && found) || add_ok || del_ok);
               rsp_in.found  = found;
               rsp_in.index  = idx_wide[3:0];
               rsp_in.count  = cnt_wide[4:0];
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Entry count exceeds the table depth.");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |-> $onehot0(match))
      else $error("More than one entry matches the requested id.");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(count_ff))
      else $error("Entry count changed outside an update.");

   a_result_timing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |=> (state_ff == ST_RESOLVE))
      else $error("Compare step was not followed by the resolve step.");
`endif

endmodule

[tb/ordered_id_set_table_core_test.sv]
// ----------------------------------------------------------------------------
// Ordered id set table core testbench
// Drives lookup, add, delete and unused operations into the table and checks
// every result against a local model of the ordered id set. A directed
// opening covers the empty table, filling to capacity, duplicates, deletes in
// the middle and at the end, and the unused code. It is followed by random
// traffic on a small id pool in fill and drain phases. Both channels stall in
// random bursts, except at the end of the run.
// ----------------------------------------------------------------------------
module ordered_id_set_table_core_test;
   import oidst_pkg::*;

   localparam int     TABLE_DEPTH    = 16;
   localparam int     RANDOM_ITEMS   = 600;
   localparam int     QUIET_ITEMS    = 100;
   localparam int     POOL_SIZE      = 20;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam op_type OP_UNUSED      = 2'd3;

   typedef struct {
      req_type item;
      rsp_type outcome;
   } expected_type;

   class id_table_scoreboard;
      logic [31:0]  slot_ids[TABLE_DEPTH];
      logic [31:0]  slot_data[TABLE_DEPTH];
      logic [4:0]   slot_count;
      expected_type awaited[$];
      int           mismatches;

      function new();
         slot_count = '0;
         mismatches = 0;
         foreach (slot_ids[i]) begin
            slot_ids[i]  = '0;
            slot_data[i] = '0;
         end
      endfunction

      function rsp_type apply_op(req_type item);
         rsp_type r;
         int      hit;
         int      i;
         hit = -1;
         for (i = 0; i < slot_count; i++) begin
            if (hit < 0 && slot_ids[i] == item.conn_id) begin
               hit = i;
            end
         end
         r.found  = (hit >= 0);
         r.index  = (hit >= 0) ? 4'(hit) : 4'd0;
         r.status = 1'b1;
         case (item.op)
            OP_LOOKUP: begin
               r.status = !r.found;
            end
            OP_ADD: begin
               if (!r.found && slot_count < TABLE_DEPTH) begin
                  slot_ids[slot_count]  = item.conn_id;
                  slot_data[slot_count] = item.entry_payload;
                  slot_count++;
                  r.status = 1'b0;
               end
            end
            OP_DELETE: begin
               if (r.found) begin
                  for (i = hit; i + 1 < slot_count; i++) begin
                     slot_ids[i]  = slot_ids[i + 1];
                     slot_data[i] = slot_data[i + 1];
                  end
                  slot_count--;
                  slot_ids[slot_count]  = '0;
                  slot_data[slot_count] = '0;
                  r.status = 1'b0;
               end
            end
            default: begin
            end
         endcase
         r.count = slot_count;
         return r;
      endfunction

      function void note_request(req_type item);
         expected_type e;
         e.item    = item;
         e.outcome = apply_op(item);
         awaited.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         expected_type e;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: status %0d found %0d index %0d count %0d",
                        got.status, got.found, got.index, got.count);
            end
         end else begin
            e = awaited.pop_front();
            if (got.status !== e.outcome.status || got.found !== e.outcome.found ||
                got.index !== e.outcome.index || got.count !== e.outcome.count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch op %0d id %h: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           e.item.op, e.item.conn_id, e.outcome.status, e.outcome.found,
                           e.outcome.index, e.outcome.count, got.status, got.found,
                           got.index, got.count);
               end
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   bit                 quiet_phase;
   logic [31:0]        id_pool[POOL_SIZE];
   int                 idle_cycles;
   id_table_scoreboard scoreboard = new();

   ordered_id_set_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            scoreboard.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            scoreboard.check_response(rsp_data);
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      repeat (7) @(posedge clock);
      forever begin
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   function automatic req_type make_item(op_type op, logic [31:0] id, logic [31:0] payload);
      req_type item;
      item.op            = op;
      item.conn_id       = id;
      item.entry_payload = payload;
      return item;
   endfunction

   function automatic req_type random_item(bit fill_phase);
      req_type item;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         item.op = OP_UNUSED;
      end else if (roll < 25) begin
         item.op = OP_LOOKUP;
      end else if (roll < (fill_phase ? 80 : 45)) begin
         item.op = OP_ADD;
      end else begin
         item.op = OP_DELETE;
      end
      item.conn_id = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : id_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 9))
         0:       item.entry_payload = '0;
         1:       item.entry_payload = '1;
         default: item.entry_payload = $urandom;
      endcase
      return item;
   endfunction

   task automatic send_item(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic push_item(req_type item);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      send_item(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending() != 0);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      quiet_phase = 1'b0;
      idle_cycles = 0;
      id_pool[0]  = 32'h0000_0000;
      id_pool[1]  = 32'hffff_ffff;
      for (int i = 2; i < POOL_SIZE; i++) begin
         id_pool[i] = $urandom;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_item(make_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
      push_item(make_item(OP_DELETE, 32'hffff_ffff, 32'hffff_ffff));
      push_item(make_item(OP_UNUSED, 32'h0000_0000, 32'hffff_ffff));
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         push_item(make_item(OP_ADD,
                             (i == 0) ? 32'h0000_0000 :
                             (i == TABLE_DEPTH - 1) ? 32'hffff_ffff : 32'h1000_0000 + i,
                             (i % 2) ? 32'hffff_ffff : 32'h0000_0000));
      end
      push_item(make_item(OP_ADD, 32'h8000_0000, 32'h5a5a_5a5a));
      push_item(make_item(OP_ADD, 32'hffff_ffff, 32'h0000_0000));
      push_item(make_item(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000));
      push_item(make_item(OP_DELETE, 32'h1000_0005, 32'h0000_0000));
      push_item(make_item(OP_DELETE, 32'hffff_ffff, 32'h0000_0000));
      push_item(make_item(OP_UNUSED, 32'h1000_0007, 32'h0000_0000));
      push_item(make_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet_phase = 1'b1;
         end
         if (n == RANDOM_ITEMS / 2) begin
            wait_drained();
         end
         push_item(random_item(((n / 40) % 2) == 0));
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
